[rtl/core/cscan_pkg.sv]
`timescale 1ns / 1ps

package cscan_pkg;

    localparam int unsigned TRACK_W  = 10;
    localparam int unsigned ID_W     = 4;
    localparam int unsigned STATUS_W = 2;

    // Input kinds
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANT        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IDLE_RELEASE = 2'd2;

    // One pending-table entry; track in the upper bits so that a plain
    // compare orders by track, then by requester id.
    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [ID_W-1:0]    id;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

[rtl/core/cscan_disk_request_scheduler_unit.sv]
`timescale 1ns / 1ps

// C-SCAN disk request scheduler.
// Input channel (item_valid / item_ready) carries one word per request or
// release: kind, track, requester_id. Output channel (result_valid /
// result_ready) carries at most one result word per input word: status,
// grant_id, grant_track.
// A request on an idle disk is granted at once. A request on a busy disk
// waits in a pending table (QUEUE_DEPTH entries, held in a one-port-write,
// one-port-read RAM); a full table gives a rejected result. A release hands
// the disk to the smallest pending track at or above the head, else wraps
// to the smallest pending track; ties go to the lowest requester id.
// Timing: a word is taken only in the idle state, one word at a time.
//   queued request: serial free-slot search from entry 0
//   request on a full table: the search runs to the last entry
//   release on busy disk: serial scan of the pending RAM through its
//   single read port (one entry per cycle), then the pick of the grant.
// The result lands in an output register; a stalled receiver only holds the
// block once a second result is ready while the first is still waiting.
// Reset clears busy, head track and all pending valid bits at once; the RAM
// contents are not cleared and no clearing pass runs.

module cscan_disk_request_scheduler_unit
    import cscan_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16,
    parameter int unsigned TRACK_COUNT = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                kind,
    input  logic [TRACK_W-1:0]  track,
    input  logic [ID_W-1:0]     requester_id,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     grant_id,
    output logic [TRACK_W-1:0]  grant_track
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [TRACK_W-1:0] TRACK_MAX = TRACK_W'(TRACK_COUNT - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // wait for an input word
    localparam logic [2:0] S_FREE  = 3'd1;  // search for a free entry
    localparam logic [2:0] S_SCAN  = 3'd2;  // issue RAM reads, one per cycle
    localparam logic [2:0] S_DRAIN = 3'd3;  // compare the last read entry
    localparam logic [2:0] S_PICK  = 3'd4;  // choose the grant
    localparam logic [2:0] S_EMIT  = 3'd5;  // move result to output register

    logic [2:0]             state_reg, state_next;
    logic                   busy_reg, busy_next;
    logic [TRACK_W-1:0]     head_track_reg, head_track_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    entry_t                 lat_reg, lat_next;
    logic [IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   ahead_found_reg, ahead_found_next;
    entry_t                 ahead_reg, ahead_next;
    logic [IDX_W-1:0]       ahead_idx_reg, ahead_idx_next;
    logic                   low_found_reg, low_found_next;
    entry_t                 low_reg, low_next;
    logic [IDX_W-1:0]       low_idx_reg, low_idx_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    entry_t                 res_reg, res_next;
    logic                   result_valid_reg, result_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    entry_t                 out_reg, out_next;

    logic                   item_accept;
    logic [TRACK_W-1:0]     sat_track;
    entry_t                 ram_rdata;
    logic [ENTRY_W-1:0]     ram_rdata_raw;
    logic                   ram_we;

    assign item_ready   = (state_reg == S_IDLE);
    assign item_accept  = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign status       = out_status_reg;
    assign grant_id     = out_reg.id;
    assign grant_track  = out_reg.track;

    // Clamp tracks beyond the disk to its last track
    assign sat_track = (32'(track) >= 32'(TRACK_COUNT)) ? TRACK_MAX : track;

    assign ram_we    = (state_reg == S_FREE) && !valid_reg[scan_idx_reg];
    assign ram_rdata = entry_t'(ram_rdata_raw);

    cscan_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_pending_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (scan_idx_reg),
        .wdata (ENTRY_W'(lat_reg)),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata_raw)
    );

    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        head_track_next   = head_track_reg;
        valid_next        = valid_reg;
        lat_next          = lat_reg;
        scan_idx_next     = scan_idx_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        ahead_found_next  = ahead_found_reg;
        ahead_next        = ahead_reg;
        ahead_idx_next    = ahead_idx_reg;
        low_found_next    = low_found_reg;
        low_next          = low_reg;
        low_idx_next      = low_idx_reg;
        res_status_next   = res_status_reg;
        res_next          = res_reg;
        result_valid_next = result_valid_reg && !result_ready;
        out_status_next   = out_status_reg;
        out_next          = out_reg;

        // Fold the entry read last cycle into both running minima. Entries
        // arrive in index order, so a strict compare keeps the lower index.
        if (cmp_vld_reg && valid_reg[cmp_idx_reg])
        begin
            if ((ram_rdata.track >= head_track_reg)
                && (!ahead_found_reg || (ram_rdata < ahead_reg)))
            begin
                ahead_found_next = 1'b1;
                ahead_next       = ram_rdata;
                ahead_idx_next   = cmp_idx_reg;
            end
            if (!low_found_reg || (ram_rdata < low_reg))
            begin
                low_found_next = 1'b1;
                low_next       = ram_rdata;
                low_idx_next   = cmp_idx_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    lat_next.track = sat_track;
                    lat_next.id    = requester_id;
                    scan_idx_next  = '0;
                    if (kind == KIND_REQUEST)
                    begin
                        if (!busy_reg)
                        begin
                            // Idle disk: grant now and move the head
                            busy_next       = 1'b1;
                            head_track_next = sat_track;
                            res_status_next = ST_GRANT;
                            res_next.track  = sat_track;
                            res_next.id     = requester_id;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_FREE;
                        end
                    end
                    else
                    begin
                        if (!busy_reg)
                        begin
                            res_status_next = ST_IDLE_RELEASE;
                            res_next        = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            ahead_found_next = 1'b0;
                            low_found_next   = 1'b0;
                            state_next       = S_SCAN;
                        end
                    end
                end
            end

            S_FREE:
            begin
                if (!valid_reg[scan_idx_reg])
                begin
                    // Take the lowest free entry; RAM write happens now
                    valid_next[scan_idx_reg] = 1'b1;
                    state_next               = S_IDLE;
                end
                else if (scan_idx_reg == LAST_IDX)
                begin
                    res_status_next = ST_FULL;
                    res_next        = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_SCAN:
            begin
                cmp_vld_next = 1'b1;
                cmp_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_DRAIN:
            begin
                state_next = S_PICK;
            end

            S_PICK:
            begin
                if (!low_found_reg)
                begin
                    // Nothing pending: drop to idle, head stays
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (ahead_found_reg)
                begin
                    valid_next[ahead_idx_reg] = 1'b0;
                    head_track_next           = ahead_reg.track;
                    res_status_next           = ST_GRANT;
                    res_next                  = ahead_reg;
                    state_next                = S_EMIT;
                end
                else
                begin
                    // Wrap around to the lowest pending track
                    valid_next[low_idx_reg] = 1'b0;
                    head_track_next         = low_reg.track;
                    res_status_next         = ST_GRANT;
                    res_next                = low_reg;
                    state_next              = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    out_status_next   = res_status_reg;
                    out_next          = res_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            busy_reg         <= 1'b0;
            head_track_reg   <= '0;
            valid_reg        <= '0;
            cmp_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            busy_reg         <= busy_next;
            head_track_reg   <= head_track_next;
            valid_reg        <= valid_next;
            cmp_vld_reg      <= cmp_vld_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_reg         <= lat_next;
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        ahead_found_reg <= ahead_found_next;
        ahead_reg       <= ahead_next;
        ahead_idx_reg   <= ahead_idx_next;
        low_found_reg   <= low_found_next;
        low_reg         <= low_next;
        low_idx_reg     <= low_idx_next;
        res_status_reg  <= res_status_next;
        res_reg         <= res_next;
        out_status_reg  <= out_status_next;
        out_reg         <= out_next;
    end

    // An idle disk never has requests waiting
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (valid_reg == '0))
        else $error("pending entries while disk idle");

    // The disk goes idle only after a release scan found nothing
    a_idle_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> ($past(state_reg) == S_PICK))
        else $error("busy dropped outside release pick");

    // A full-table rejection only when every entry is taken
    a_full_is_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && res_status_reg == ST_FULL)
            |-> ($countones(valid_reg) == QUEUE_DEPTH))
        else $error("table-full result with a free entry");

    // No compare left in flight once the sequencer is idle
    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmp_vld_reg)
        else $error("scan compare pending in idle");

endmodule

[rtl/core/cscan_ram.sv]
`timescale 1ns / 1ps

module cscan_ram #(
    parameter int unsigned WIDTH = 14,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Self-checking bench for the C-SCAN disk request scheduler.
module testbench;
    import cscan_pkg::*;

    localparam int QDEPTH          = 16;
    localparam int RANDOM_WORDS    = 430;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int DRAIN_CYCLES    = 2 * QDEPTH + 10;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PLAN_LEN        = 26;

    // One result word as the block returns it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [TRACK_W-1:0]  track;
    } grant_word_t;

    // One directed row: the input word, plus a hand-typed result where the
    // answer is obvious; every other row is checked against the predictor.
    typedef struct packed {
        logic               k;
        logic [TRACK_W-1:0] trk;
        logic [ID_W-1:0]    rid;
        logic               typed;
        grant_word_t        want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic                kind;
    logic [TRACK_W-1:0]  track;
    logic [ID_W-1:0]     requester_id;
    logic                result_valid;
    logic                result_ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     grant_id;
    logic [TRACK_W-1:0]  grant_track;

    // Predictor state: our own copy of the disk and its pending table.
    logic               disk_owned;
    logic [TRACK_W-1:0] head_pos;
    logic               slot_used  [QDEPTH];
    logic [TRACK_W-1:0] slot_track [QDEPTH];
    logic [ID_W-1:0]    slot_owner [QDEPTH];

    grant_word_t due_grants [$];
    plan_row_t   plan [PLAN_LEN];

    int errors         = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int status_hits [4];
    int quiet_cycles   = 0;
    int sender_idle_pct;
    int recv_idle_pct;
    bit held_off       = 1'b0;

    cscan_disk_request_scheduler_unit #(
        .QUEUE_DEPTH (QDEPTH),
        .TRACK_COUNT (1024)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .kind         (kind),
        .track        (track),
        .requester_id (requester_id),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .grant_id     (grant_id),
        .grant_track  (grant_track)
    );

    // 10 ns clock: five high, five low.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sort key of a pending entry: track first, then requester id. Scanning
    // in index order with a strict compare leaves ties on the lowest index.
    function automatic logic [TRACK_W+ID_W-1:0] slot_key(input int i);
        return {slot_track[i], slot_owner[i]};
    endfunction

    // Advance the predicted scheduler by one accepted word and return the
    // result word it owes, if any.
    task automatic schedule_word(input logic k, input logic [TRACK_W-1:0] trk,
                                 input logic [ID_W-1:0] rid,
                                 output bit has_word, output grant_word_t w);
        int i;
        int free_slot;
        int ahead;
        int lowest;
        int pick;
        has_word  = 1'b0;
        w         = '0;
        free_slot = -1;
        ahead     = -1;
        lowest    = -1;
        if (k == KIND_REQUEST)
        begin
            if (!disk_owned)
            begin
                // Idle disk: grant at once and move the head.
                disk_owned = 1'b1;
                head_pos   = trk;
                has_word   = 1'b1;
                w          = '{ST_GRANT, rid, trk};
            end
            else
            begin
                for (i = 0; i < QDEPTH; i++)
                    if (!slot_used[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    slot_used[free_slot]  = 1'b1;
                    slot_track[free_slot] = trk;
                    slot_owner[free_slot] = rid;
                end
                else
                begin
                    has_word = 1'b1;
                    w        = '{ST_FULL, '0, '0};
                end
            end
        end
        else if (!disk_owned)
        begin
            has_word = 1'b1;
            w        = '{ST_IDLE_RELEASE, '0, '0};
        end
        else
        begin
            for (i = 0; i < QDEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    if (slot_track[i] >= head_pos &&
                        (ahead < 0 || slot_key(i) < slot_key(ahead)))
                        ahead = i;
                    if (lowest < 0 || slot_key(i) < slot_key(lowest))
                        lowest = i;
                end
            end
            if (lowest < 0)
            begin
                // Nothing pending: go idle, keep the head.
                disk_owned = 1'b0;
            end
            else
            begin
                // Sweep upward; wrap to the lowest track when nothing is ahead.
                pick            = (ahead >= 0) ? ahead : lowest;
                slot_used[pick] = 1'b0;
                head_pos        = slot_track[pick];
                has_word        = 1'b1;
                w               = '{ST_GRANT, slot_owner[pick], slot_track[pick]};
            end
        end
    endtask

    // Offer one word, idling first at the current rate, and hold it until
    // the block takes it. Entered and left at a falling edge.
    task automatic send_word(input logic k, input logic [TRACK_W-1:0] trk,
                             input logic [ID_W-1:0] rid, input logic typed,
                             input grant_word_t typed_word);
        bit          has_word;
        grant_word_t w;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        track        <= trk;
        requester_id <= rid;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        schedule_word(k, trk, rid, has_word, w);
        if (typed)
            due_grants.push_back(typed_word);
        else if (has_word)
            due_grants.push_back(w);
        words_sent++;
        @(negedge clk);
    endtask

    // Bias tracks toward the ends and a shared middle so that ties and the
    // wrap happen often.
    function automatic logic [TRACK_W-1:0] pick_track();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return TRACK_W'(512);
            default: return TRACK_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return ID_W'($urandom_range(15));
        endcase
    endfunction

    // Report one field that differs from the prediction.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Result monitor: match each accepted result word against the oldest
    // owed word.
    always @(posedge clk)
    begin
        grant_word_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            status_hits[status]++;
            if (due_grants.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d id %0d track %0d",
                         $time, status, grant_id, grant_track);
                errors++;
            end
            else
            begin
                want = due_grants.pop_front();
                check_field("status", want.status, status);
                check_field("grant_id", want.id, grant_id);
                check_field("grant_track", want.track, grant_track);
            end
        end
    end

    // Watchdog: end the run once nothing has moved on either channel for
    // too long.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no handshake for %0d cycles, %0d results owed",
                     $time, quiet_cycles, due_grants.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: stall at the current rate. Once, after a few dozen results,
    // hold ready low for a long stretch so that the output register fills,
    // the block stalls and the sender backs up behind it.
    initial
    begin
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            result_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Main sequence: reset, directed table, random bursts, drain, verdict.
    initial
    begin
        int          r;
        int          n_req;
        int          n_rel;
        int          random_sent;
        grant_word_t none;

        none         = '0;
        item_valid   = 1'b0;
        kind         = KIND_REQUEST;
        track        = '0;
        requester_id = '0;
        rst_n        = 1'b0;
        for (r = 0; r < 4; r++)
            status_hits[r] = 0;

        // Reset the predictor the way the block resets.
        disk_owned = 1'b0;
        head_pos   = '0;
        for (r = 0; r < QDEPTH; r++)
        begin
            slot_used[r]  = 1'b0;
            slot_track[r] = '0;
            slot_owner[r] = '0;
        end

        // Directed rows. Head starts at 0 after reset.
        plan[0]  = '{KIND_RELEASE, 10'd0,    4'd0,  1'b1, '{ST_IDLE_RELEASE, 4'd0, 10'd0}};
        plan[1]  = '{KIND_REQUEST, 10'd0,    4'd0,  1'b1, '{ST_GRANT, 4'd0, 10'd0}};
        // Queue behind the owner: extremes, a shared track, an exact duplicate.
        plan[2]  = '{KIND_REQUEST, 10'd1023, 4'd15, 1'b0, none};
        plan[3]  = '{KIND_REQUEST, 10'd500,  4'd9,  1'b0, none};
        plan[4]  = '{KIND_REQUEST, 10'd500,  4'd3,  1'b0, none};
        plan[5]  = '{KIND_REQUEST, 10'd0,    4'd7,  1'b0, none};
        plan[6]  = '{KIND_REQUEST, 10'd500,  4'd3,  1'b0, none};
        // Drain upward: track at the head, id tie, index tie, top track.
        plan[7]  = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[8]  = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[9]  = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[10] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[11] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        // Empty table: go idle silently, then a release on the idle disk.
        plan[12] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[13] = '{KIND_RELEASE, 10'd1023, 4'd15, 1'b1, '{ST_IDLE_RELEASE, 4'd0, 10'd0}};
        // Sweep from the middle and wrap round.
        plan[14] = '{KIND_REQUEST, 10'd600,  4'd1,  1'b1, '{ST_GRANT, 4'd1, 10'd600}};
        plan[15] = '{KIND_REQUEST, 10'd100,  4'd2,  1'b0, none};
        plan[16] = '{KIND_REQUEST, 10'd700,  4'd4,  1'b0, none};
        plan[17] = '{KIND_REQUEST, 10'd200,  4'd5,  1'b0, none};
        plan[18] = '{KIND_REQUEST, 10'd600,  4'd6,  1'b0, none};
        plan[19] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[20] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[21] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[22] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[23] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};
        plan[24] = '{KIND_REQUEST, 10'd1023, 4'd15, 1'b1, '{ST_GRANT, 4'd15, 10'd1023}};
        plan[25] = '{KIND_RELEASE, 10'd0,    4'd0,  1'b0, none};

        // Hold reset low, then release it away from the rising edge.
        sender_idle_pct = 31;
        recv_idle_pct   = 64;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (r = 0; r < PLAN_LEN; r++)
            send_word(plan[r].k, plan[r].trk, plan[r].rid, plan[r].typed, plan[r].want);

        // Random bursts: mostly one grant, a run of requests that often
        // overflows the table, then a run of releases; some pure noise.
        random_sent = 0;
        while (random_sent < RANDOM_WORDS)
        begin
            // Swap the idle rates a third of the way in, then stop idling.
            if (random_sent < RANDOM_WORDS / 3)
            begin
                sender_idle_pct = 31;
                recv_idle_pct   = 64;
            end
            else if (random_sent < 2 * RANDOM_WORDS / 3)
            begin
                sender_idle_pct = 64;
                recv_idle_pct   = 31;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end

            if ($urandom_range(99) < 15)
            begin
                n_req = $urandom_range(1, 3);
                for (r = 0; r < n_req; r++)
                    send_word(1'($urandom_range(1)), TRACK_W'($urandom_range(1023)),
                              ID_W'($urandom_range(15)), 1'b0, none);
                random_sent += n_req;
            end
            else
            begin
                n_req = $urandom_range(1, QDEPTH + 4);
                n_rel = $urandom_range(0, n_req + 2);
                for (r = 0; r < n_req; r++)
                    send_word(KIND_REQUEST, pick_track(), pick_id(), 1'b0, none);
                // Random payload on releases too: the block must ignore it.
                for (r = 0; r < n_rel; r++)
                    send_word(KIND_RELEASE, TRACK_W'($urandom_range(1023)),
                              ID_W'($urandom_range(15)), 1'b0, none);
                random_sent += n_req + n_rel;
            end
        end
        item_valid <= 1'b0;

        // Wait for every owed word, then give a silent item time to misfire.
        while (due_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d words, checked %0d results: %0d grants, %0d rejected, %0d idle",
                 words_sent, results_seen, status_hits[ST_GRANT], status_hits[ST_FULL],
                 status_hits[ST_IDLE_RELEASE]);
        $display("Receiver hold-off %s, %0d mismatches",
                 held_off ? "exercised" : "not reached", errors);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/cscan_pkg.sv
rtl/core/cscan_ram.sv
rtl/core/cscan_disk_request_scheduler_unit.sv
tb/testbench.sv
